// File: design/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared constants and types for the banked memory map decoder.
// ----------------------------------------------------------------------------
package bmmd_pkg;

  localparam int DefWorkRamBanks  = 8;
  localparam int DefVideoRamBanks = 2;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Decoded target of one access
  typedef enum logic [4:0] {
    T_OUTSIDE, T_NONE, T_VRAM, T_WRAM, T_OAM, T_HRAM, T_WAVE, T_BGPAL, T_OBJPAL,
    T_IF, T_IE, T_DISP, T_KEY1, T_VBK, T_HDMA1, T_HDMA2, T_HDMA3, T_HDMA4,
    T_BCPS, T_OCPS, T_SVBK
  } target_t;

endpackage

// File: design/banked_memory_map_decoder_unit.sv
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_unit
// Bus access decoder with banked work/video RAM, small RAMs and registers.
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        input      in_valid, in_stall, command, address, write_data,
//                      double_speed_now
// out       output     out_valid, out_stall, read_data, claimed
// cfg       input      cfg_we, cfg_wdata (color_mode)
//
// Each item passes a decode/memory-read stage, then the output register.
// No new item is accepted while one is in the read stage; the item after
// it is accepted while the result waits, once the output register is free.
// Reset clears valid flags and control registers; memory and data stay undefined.
// A stalled output holds its result and blocks the next accept.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder_unit #(
  parameter int WORK_RAM_BANKS  = bmmd_pkg::DefWorkRamBanks,
  parameter int VIDEO_RAM_BANKS = bmmd_pkg::DefVideoRamBanks
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic        double_speed_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        claimed
);
  import bmmd_pkg::*;

  localparam int WramDepth = WORK_RAM_BANKS * 4096;
  localparam int VramDepth = VIDEO_RAM_BANKS * 8192;
  localparam int WaW = $clog2(WramDepth);
  localparam int VaW = $clog2(VramDepth);

  logic color_mode;
  logic [7:0] wram [WramDepth];
  logic [7:0] vram [VramDepth];
  logic [7:0] oam [160];
  logic [7:0] hram [127];
  logic [7:0] wave [16];
  logic [7:0] bgpal [64];
  logic [7:0] objpal [64];
  logic [5:0] bg_idx, obj_idx;
  logic bg_inc, obj_inc;
  logic [2:0] work_bank;
  logic video_bank, speed_pend;
  logic [7:0] ie_reg, if_reg;
  logic [15:0] hdma_src, hdma_dst;
  logic [7:0] disp [8];

  // stage 1: memory read in flight
  logic s1_valid, s1_wr;
  target_t s1_tgt;
  logic [7:0] s1_reg, s1_mem;

  logic accept;
  assign in_stall = s1_valid || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;

  target_t tgt;
  logic [2:0] slot;
  logic [2:0] wbank_phys;
  logic [WaW-1:0] wa;
  logic [VaW-1:0] va;
  logic [2:0] wb;

  always_comb begin
    tgt  = T_NONE;
    slot = '0;
    if (address < 16'h8000 || (address >= 16'hA000 && address < 16'hC000) ||
        (address >= 16'hFF00 && address <= 16'hFF02) ||
        (address >= 16'hFF04 && address <= 16'hFF07) ||
        (address >= 16'hFF10 && address <= 16'hFF14) ||
        (address >= 16'hFF16 && address <= 16'hFF1E) ||
        (address >= 16'hFF20 && address <= 16'hFF26) ||
        address == 16'hFF40 || address == 16'hFF41 || address == 16'hFF44 ||
        address == 16'hFF46 || (address == 16'hFF55 && color_mode))
      tgt = T_OUTSIDE;
    else if (address < 16'hA000) tgt = T_VRAM;
    else if (address < 16'hFE00) tgt = T_WRAM;
    else if (address < 16'hFEA0) tgt = T_OAM;
    else if (address >= 16'hFF80 && address != 16'hFFFF) tgt = T_HRAM;
    else if (address >= 16'hFF30 && address < 16'hFF40) tgt = T_WAVE;
    else if (address == 16'hFF0F) tgt = T_IF;
    else if (address == 16'hFFFF) tgt = T_IE;
    else begin
      unique case (address)
        16'hFF42: begin tgt = T_DISP; slot = 3'd0; end
        16'hFF43: begin tgt = T_DISP; slot = 3'd1; end
        16'hFF45: begin tgt = T_DISP; slot = 3'd2; end
        16'hFF47: begin tgt = T_DISP; slot = 3'd3; end
        16'hFF48: begin tgt = T_DISP; slot = 3'd4; end
        16'hFF49: begin tgt = T_DISP; slot = 3'd5; end
        16'hFF4A: begin tgt = T_DISP; slot = 3'd6; end
        16'hFF4B: begin tgt = T_DISP; slot = 3'd7; end
        16'hFF4D: if (color_mode) tgt = T_KEY1;
        16'hFF4F: if (color_mode) tgt = T_VBK;
        16'hFF51: if (color_mode) tgt = T_HDMA1;
        16'hFF52: if (color_mode) tgt = T_HDMA2;
        16'hFF53: if (color_mode) tgt = T_HDMA3;
        16'hFF54: if (color_mode) tgt = T_HDMA4;
        16'hFF68: if (color_mode) tgt = T_BCPS;
        16'hFF69: if (color_mode) tgt = T_BGPAL;
        16'hFF6A: if (color_mode) tgt = T_OCPS;
        16'hFF6B: if (color_mode) tgt = T_OBJPAL;
        16'hFF70: if (color_mode) tgt = T_SVBK;
        default: tgt = T_NONE;
      endcase
    end
    // work RAM: echo shares the offsets, the upper 4 KB window takes the
    // bank register with bank 0 counted as 1
    wb = (work_bank == 3'd0) ? 3'd1 : work_bank;
    wbank_phys = address[12] ? wb : 3'd0;
    // wrap the bank onto the fitted banks
    for (int k = 0; k < 3; k++) begin
      if (int'(wbank_phys) >= WORK_RAM_BANKS)
        wbank_phys = wbank_phys - 3'(WORK_RAM_BANKS);
    end
    wa = WaW'({wbank_phys, address[11:0]});
    va = VaW'(({4'b0, address[12:0]} + (video_bank ? 17'h2000 : 17'h0)) % 17'(VramDepth));
  end

  // memories: reads and writes of all memories in one clocked block
  always_ff @(posedge clk) begin
    if (accept && tgt == T_VRAM) begin
      if (command == CMD_WRITE) vram[va] <= write_data;
      s1_mem <= vram[va];
    end else if (accept && tgt == T_WRAM) begin
      if (command == CMD_WRITE) wram[wa] <= write_data;
      s1_mem <= wram[wa];
    end else if (accept && tgt == T_OAM) begin
      if (command == CMD_WRITE) oam[address[7:0]] <= write_data;
      s1_mem <= oam[address[7:0]];
    end else if (accept && tgt == T_HRAM) begin
      if (command == CMD_WRITE) hram[address[6:0]] <= write_data;
      s1_mem <= hram[address[6:0]];
    end else if (accept && tgt == T_WAVE) begin
      if (command == CMD_WRITE) wave[address[3:0]] <= write_data;
      s1_mem <= wave[address[3:0]];
    end else if (accept && tgt == T_BGPAL) begin
      if (command == CMD_WRITE) bgpal[bg_idx] <= write_data;
      s1_mem <= bgpal[bg_idx];
    end else if (accept && tgt == T_OBJPAL) begin
      if (command == CMD_WRITE) objpal[obj_idx] <= write_data;
      s1_mem <= objpal[obj_idx];
    end
  end

  logic [7:0] reg_rd;
  always_comb begin
    case (tgt)
      T_IF:    reg_rd = if_reg;
      T_IE:    reg_rd = ie_reg;
      T_DISP:  reg_rd = disp[slot];
      T_KEY1:  reg_rd = {double_speed_now, 6'h3F, speed_pend};
      T_VBK:   reg_rd = {7'h7F, video_bank};
      T_HDMA1: reg_rd = hdma_src[15:8];
      T_HDMA2: reg_rd = hdma_src[7:0];
      T_HDMA3: reg_rd = hdma_dst[15:8];
      T_HDMA4: reg_rd = hdma_dst[7:0];
      T_BCPS:  reg_rd = {bg_inc, 1'b0, bg_idx};
      T_OCPS:  reg_rd = {obj_inc, 1'b0, obj_idx};
      T_SVBK:  reg_rd = {5'h1F, work_bank};
      default: reg_rd = 8'hFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr  <= command;
      s1_tgt <= tgt;
      s1_reg <= reg_rd;
    end
    if (s1_valid) begin
      claimed   <= (s1_tgt != T_OUTSIDE);
      read_data <= (s1_wr || s1_tgt == T_OUTSIDE) ? 8'hFF :
                   (s1_tgt == T_VRAM || s1_tgt == T_WRAM || s1_tgt == T_OAM ||
                    s1_tgt == T_HRAM || s1_tgt == T_WAVE || s1_tgt == T_BGPAL ||
                    s1_tgt == T_OBJPAL) ? s1_mem : s1_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      color_mode <= 1'b0;
      bg_idx <= '0; bg_inc <= 1'b0; obj_idx <= '0; obj_inc <= 1'b0;
      work_bank <= '0; video_bank <= 1'b0; speed_pend <= 1'b0;
      ie_reg <= '0; if_reg <= '0; hdma_src <= '0; hdma_dst <= '0;
      for (int i = 0; i < 8; i++) disp[i] <= '0;
    end else begin
      if (cfg_we) color_mode <= cfg_wdata;
      s1_valid <= accept;
      if (s1_valid) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (accept && command == CMD_WRITE) begin
        case (tgt)
          T_IF:    if_reg <= write_data | 8'hE0;
          T_IE:    ie_reg <= write_data;
          T_DISP:  disp[slot] <= write_data;
          T_KEY1:  speed_pend <= write_data[0];
          T_VBK:   video_bank <= write_data[0];
          T_HDMA1: hdma_src[15:8] <= write_data;
          T_HDMA2: hdma_src[7:0] <= {write_data[7:4], 4'h0};
          T_HDMA3: hdma_dst[15:8] <= write_data;
          T_HDMA4: hdma_dst[7:0] <= {write_data[7:4], 4'h0};
          T_BCPS:  begin bg_inc <= write_data[7]; bg_idx <= write_data[5:0]; end
          T_OCPS:  begin obj_inc <= write_data[7]; obj_idx <= write_data[5:0]; end
          T_BGPAL: if (bg_inc) bg_idx <= bg_idx + 6'd1;
          T_OBJPAL: if (obj_inc) obj_idx <= obj_idx + 6'd1;
          T_SVBK:  work_bank <= write_data[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/banked_memory_map_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_map_decoder_unit_tb
// Drives random and directed bus accesses through the decoder, predicts the
// returned byte and claim flag from a behavioral copy of the memory map, and
// compares every result in order. Runs several idle/stall phases and both
// settings of color_mode.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder_unit_tb;
  import bmmd_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        ds;
  } access_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       claim;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic        double_speed_now;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  read_data;
  logic        claimed;

  banked_memory_map_decoder_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .command(command),
    .address(address), .write_data(write_data),
    .double_speed_now(double_speed_now), .out_valid(out_valid),
    .out_stall(out_stall), .read_data(read_data), .claimed(claimed)
  );

  // Behavioral copy of the map state
  logic [7:0]  m_wram [32768];
  logic [7:0]  m_vram [16384];
  logic [7:0]  m_oam [160];
  logic [7:0]  m_hram [127];
  logic [7:0]  m_wave [16];
  logic [7:0]  m_bgpal [64];
  logic [7:0]  m_objpal [64];
  bit          w_wram [32768];
  bit          w_vram [16384];
  bit          w_oam [160];
  bit          w_hram [127];
  bit          w_wave [16];
  bit          w_bgpal [64];
  bit          w_objpal [64];
  logic [5:0]  bg_idx, obj_idx;
  logic        bg_inc, obj_inc;
  logic [2:0]  wbank;
  logic        vbank;
  logic [7:0]  ie_reg, if_reg;
  logic        key1_pend;
  logic [15:0] hdma_src, hdma_dst;
  logic [7:0]  disp [8];
  logic        color_on;

  access_t pending_q[$];
  reply_t  expected_q[$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // Stall as seen at the last rising edge: tells the driver if its item went in
  logic in_stall_seen;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int disp_slot(logic [15:0] a);
    case (a)
      16'hff42: return 0;
      16'hff43: return 1;
      16'hff45: return 2;
      16'hff47: return 3;
      16'hff48: return 4;
      16'hff49: return 5;
      16'hff4a: return 6;
      16'hff4b: return 7;
      default:  return -1;
    endcase
  endfunction

  function automatic bit routed_out(logic [15:0] a);
    return a < 16'h8000 || (a >= 16'ha000 && a < 16'hc000) ||
      (a >= 16'hff00 && a <= 16'hff02) || (a >= 16'hff04 && a <= 16'hff07) ||
      (a >= 16'hff10 && a <= 16'hff14) || (a >= 16'hff16 && a <= 16'hff1e) ||
      (a >= 16'hff20 && a <= 16'hff26) || a == 16'hff40 || a == 16'hff41 ||
      a == 16'hff44 || a == 16'hff46 || (a == 16'hff55 && color_on);
  endfunction

  function automatic int wram_offset(logic [15:0] a);
    int off;
    int b;
    off = (a >= 16'he000) ? a - 16'he000 : a - 16'hc000;
    if (off >= 'h1000) begin
      b = (wbank == 0) ? 1 : wbank;
      off += (b - 1) * 'h1000;
    end
    return off % 32768;
  endfunction

  // True when a read of this access would return a never-written entry
  function automatic bit reads_unwritten(access_t x);
    logic [15:0] a;
    a = x.addr;
    if (x.cmd == CMD_WRITE || routed_out(a)) return 0;
    if (a >= 16'h8000 && a < 16'ha000) return !w_vram[a - 16'h8000 + 'h2000 * vbank];
    if (a >= 16'hc000 && a < 16'hfe00) return !w_wram[wram_offset(a)];
    if (a >= 16'hfe00 && a < 16'hfea0) return !w_oam[a - 16'hfe00];
    if (a >= 16'hff80 && a < 16'hffff) return !w_hram[a - 16'hff80];
    if (a >= 16'hff30 && a < 16'hff40) return !w_wave[a - 16'hff30];
    if (color_on && a == 16'hff69) return !w_bgpal[bg_idx];
    if (color_on && a == 16'hff6b) return !w_objpal[obj_idx];
    return 0;
  endfunction

  function automatic reply_t decode_access(access_t x);
    reply_t r;
    logic [15:0] a;
    logic [7:0] v, d;
    bit wr;
    int p, s;
    a = x.addr; v = x.wdata; wr = (x.cmd == CMD_WRITE); d = 8'hff;
    if (routed_out(a)) return '{rdata: 8'hff, claim: 1'b0};
    s = disp_slot(a);
    if (a >= 16'h8000 && a < 16'ha000) begin
      p = a - 16'h8000 + 'h2000 * vbank;
      if (wr) begin m_vram[p] = v; w_vram[p] = 1; end else d = m_vram[p];
    end else if (a >= 16'hc000 && a < 16'hfe00) begin
      p = wram_offset(a);
      if (wr) begin m_wram[p] = v; w_wram[p] = 1; end else d = m_wram[p];
    end else if (a >= 16'hfe00 && a < 16'hfea0) begin
      p = a - 16'hfe00;
      if (wr) begin m_oam[p] = v; w_oam[p] = 1; end else d = m_oam[p];
    end else if (a >= 16'hff80 && a < 16'hffff) begin
      p = a - 16'hff80;
      if (wr) begin m_hram[p] = v; w_hram[p] = 1; end else d = m_hram[p];
    end else if (a >= 16'hff30 && a < 16'hff40) begin
      p = a - 16'hff30;
      if (wr) begin m_wave[p] = v; w_wave[p] = 1; end else d = m_wave[p];
    end else if (a == 16'hff0f) begin
      if (wr) if_reg = v | 8'he0; else d = if_reg;
    end else if (a == 16'hffff) begin
      if (wr) ie_reg = v; else d = ie_reg;
    end else if (s >= 0) begin
      if (wr) disp[s] = v; else d = disp[s];
    end else if (color_on) begin
      case (a)
        16'hff4d: if (wr) key1_pend = v[0]; else d = {x.ds, 6'h3f, key1_pend};
        16'hff4f: if (wr) vbank = v[0]; else d = {7'h7f, vbank};
        16'hff51: if (wr) hdma_src[15:8] = v; else d = hdma_src[15:8];
        16'hff52: if (wr) hdma_src[7:0] = v & 8'hf0; else d = hdma_src[7:0];
        16'hff53: if (wr) hdma_dst[15:8] = v; else d = hdma_dst[15:8];
        16'hff54: if (wr) hdma_dst[7:0] = v & 8'hf0; else d = hdma_dst[7:0];
        16'hff68: if (wr) begin bg_inc = v[7]; bg_idx = v[5:0]; end
                  else d = {bg_inc, 1'b0, bg_idx};
        16'hff69: if (wr) begin
                    m_bgpal[bg_idx] = v; w_bgpal[bg_idx] = 1;
                    if (bg_inc) bg_idx = bg_idx + 6'd1;
                  end else d = m_bgpal[bg_idx];
        16'hff6a: if (wr) begin obj_inc = v[7]; obj_idx = v[5:0]; end
                  else d = {obj_inc, 1'b0, obj_idx};
        16'hff6b: if (wr) begin
                    m_objpal[obj_idx] = v; w_objpal[obj_idx] = 1;
                    if (obj_inc) obj_idx = obj_idx + 6'd1;
                  end else d = m_objpal[obj_idx];
        16'hff70: if (wr) wbank = v[2:0]; else d = {5'h1f, wbank};
        default: ;
      endcase
    end
    r.rdata = wr ? 8'hff : d;
    r.claim = 1'b1;
    return r;
  endfunction

  // Driver: present items at the falling edge, hold them while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall_seen) begin
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        access_t x;
        x = pending_q.pop_front();
        in_valid <= 1'b1;
        command <= x.cmd;
        address <= x.addr;
        write_data <= x.wdata;
        double_speed_now <= x.ds;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    in_stall_seen <= in_stall;
    if (!rst && in_valid && !in_stall)
      expected_q.push_back(decode_access('{cmd: command, addr: address,
                                           wdata: write_data, ds: double_speed_now}));
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: read_data=%h claimed=%b", read_data, claimed);
        errors++;
      end else begin
        reply_t e;
        e = expected_q.pop_front();
        if (read_data !== e.rdata) begin
          $error("read_data expected %h actual %h", e.rdata, read_data);
          errors++;
        end
        if (claimed !== e.claim) begin
          $error("claimed expected %b actual %b", e.claim, claimed);
          errors++;
        end
      end
    end
  end

  // Wait until every queued item went in and every result came back
  task automatic drain();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_color(logic m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    color_on = m;
  endtask

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(15))
      0:       return 16'($urandom_range(16'h7fff));
      1:       return 16'ha000 + 16'($urandom_range(16'h1fff));
      2, 3:    return 16'h8000 + 16'($urandom_range(16'h1fff));
      4, 5, 6: return 16'hc000 + 16'($urandom_range(16'h1fff));
      7:       return 16'he000 + 16'($urandom_range(16'h1dff));
      8:       return 16'hfe00 + 16'($urandom_range(16'hff));
      9:       return 16'hff80 + 16'($urandom_range(16'h7f));
      10:      return 16'hff30 + 16'($urandom_range(15));
      11, 12:  return 16'hff00 + 16'($urandom_range(16'h7f));
      default: begin
        logic [15:0] regs [14];
        regs = '{16'hff4d, 16'hff4f, 16'hff51, 16'hff52, 16'hff53, 16'hff54,
                 16'hff55, 16'hff68, 16'hff69, 16'hff6a, 16'hff6b, 16'hff70,
                 16'hff0f, 16'hffff};
        return regs[$urandom_range(13)];
      end
    endcase
  endfunction

  // Random access; palette index writes mostly turn auto-increment on
  function automatic access_t rand_access();
    access_t x;
    x.cmd = 1'($urandom_range(1));
    x.addr = pick_addr();
    x.wdata = 8'($urandom);
    x.ds = 1'($urandom_range(1));
    if ((x.addr == 16'hff68 || x.addr == 16'hff6a) && $urandom_range(3) != 0)
      x.wdata[7] = 1'b1;
    return x;
  endfunction

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    access_t x;
    int n;
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
    command = CMD_READ; address = '0; write_data = '0; double_speed_now = 1'b0;
    in_stall_seen = 1'b0;
    bg_idx = 0; obj_idx = 0; bg_inc = 0; obj_inc = 0; wbank = 0; vbank = 0;
    ie_reg = 0; if_reg = 0; key1_pend = 0; hdma_src = 0; hdma_dst = 0;
    color_on = 0;
    foreach (disp[i]) disp[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes and colour registers, one item per batch so the
    // written-entry tracking is current when choosing reads
    for (int ph = 0; ph < 2; ph++) begin
      access_t d [14];
      set_color(ph[0]);
      d = '{'{CMD_WRITE, 16'hc000, 8'h00, 1'b0}, '{CMD_READ, 16'he000, 8'h00, 1'b1},
            '{CMD_WRITE, 16'hff70, 8'h07, 1'b0}, '{CMD_WRITE, 16'hdfff, 8'hff, 1'b0},
            '{CMD_READ, 16'hdfff, 8'h00, 1'b0}, '{CMD_WRITE, 16'hff4f, 8'hff, 1'b1},
            '{CMD_WRITE, 16'h9fff, 8'ha5, 1'b0}, '{CMD_READ, 16'hff4d, 8'h00, 1'b1},
            '{CMD_WRITE, 16'hff0f, 8'h01, 1'b0}, '{CMD_READ, 16'hff0f, 8'h00, 1'b0},
            '{CMD_WRITE, 16'hff68, 8'hbf, 1'b0}, '{CMD_WRITE, 16'hff69, 8'h5a, 1'b0},
            '{CMD_READ, 16'hff68, 8'h00, 1'b0}, '{CMD_READ, 16'h0000, 8'h00, 1'b1}};
      foreach (d[i]) begin
        if (!reads_unwritten(d[i])) begin
          pending_q.push_back(d[i]);
          drain();
        end
      end
    end

    // Random phases; each item is chosen against the predictor's current
    // state, so stimulus is fed one at a time in well-drained small bursts
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      set_color(ph < 2 || ph >= 6 ? 1'b1 : 1'b0);
      n = 0;
      while (n < 200) begin
        x = rand_access();
        // only reads that hit written storage go into the same burst as
        // other items when nothing queued could change the outcome
        if (reads_unwritten(x)) x.cmd = CMD_WRITE;
        pending_q.push_back(x);
        n++;
        // keep the predictor ahead of choice: drain when stores could change
        if (x.cmd == CMD_WRITE || $urandom_range(7) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// File: banked_memory_map_decoder_unit.f
design/bmmd_pkg.sv
design/banked_memory_map_decoder_unit.sv
tb/banked_memory_map_decoder_unit_tb.sv
